/* rtl/core/rmq_pkg.sv */
// Shared control types and component codes for the matrix-to-quaternion pipeline.
package rmq_pkg;

    // Component that takes root/2; the other three come from the dividers.
    localparam logic [1:0] LEAD_W = 2'd0;
    localparam logic [1:0] LEAD_X = 2'd1;
    localparam logic [1:0] LEAD_Y = 2'd2;
    localparam logic [1:0] LEAD_Z = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [1:0] lead;
    } rmq_ctrl_t;

endpackage

/* rtl/core/rmq_sqrt_cell.sv */
// One digit step of the integer square root chain, with the item's side data.
module rmq_sqrt_cell #(
    parameter int RW  = 17,
    parameter int DDW = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  rmq_pkg::rmq_ctrl_t ctrl_in,
    input  logic [2*RW-1:0]   x_in,
    input  logic [RW-1:0]     root_in,
    input  logic [RW+1:0]     rem_in,
    input  logic [DDW-1:0]    d_in [3],
    output rmq_pkg::rmq_ctrl_t ctrl_out,
    output logic [2*RW-1:0]   x_out,
    output logic [RW-1:0]     root_out,
    output logic [RW+1:0]     rem_out,
    output logic [DDW-1:0]    d_out [3]
);

    logic [RW+2:0] rem_s;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    assign rem_s = {rem_in[RW:0], x_in[2*RW-1:2*RW-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (rem_s >= trial);
    assign diff  = rem_s - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_out <= '0;
        end
        else if (en)
        begin
            ctrl_out <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out    <= {x_in[2*RW-3:0], 2'b00};
            root_out <= {root_in[RW-2:0], ge};
            rem_out  <= ge ? diff[RW+1:0] : rem_s[RW+1:0];
            d_out    <= d_in;
        end
    end

endmodule

/* rtl/core/rmq_div_cell.sv */
// One quotient bit for each of the three divider lanes, sharing the divisor 2*root.
module rmq_div_cell #(
    parameter int RW = 17,
    parameter int NW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  rmq_pkg::rmq_ctrl_t ctrl_in,
    input  logic [RW-1:0]     root_in,
    input  logic              neg_in [3],
    input  logic [NW-1:0]     num_in [3],
    input  logic [RW+1:0]     rem_in [3],
    input  logic [NW-1:0]     quo_in [3],
    output rmq_pkg::rmq_ctrl_t ctrl_out,
    output logic [RW-1:0]     root_out,
    output logic              neg_out [3],
    output logic [NW-1:0]     num_out [3],
    output logic [RW+1:0]     rem_out [3],
    output logic [NW-1:0]     quo_out [3]
);

    logic [RW+1:0] den;
    logic [RW+1:0] rem_s [3];
    logic          ge    [3];

    assign den = {1'b0, root_in, 1'b0};

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            rem_s[n] = {rem_in[n][RW:0], num_in[n][NW-1]};
            ge[n]    = (rem_s[n] >= den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_out <= '0;
        end
        else if (en)
        begin
            ctrl_out <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_out <= root_in;
            for (int n = 0; n < 3; n++)
            begin
                neg_out[n] <= neg_in[n];
                num_out[n] <= {num_in[n][NW-2:0], 1'b0};
                rem_out[n] <= ge[n] ? (rem_s[n] - den) : rem_s[n];
                quo_out[n] <= {quo_in[n][NW-2:0], ge[n]};
            end
        end
    end

endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Top level: 3x3 rotation matrix to unit quaternion, fully pipelined.
//
// s_axis carries one matrix per transaction: nine signed fixed-point elements
// m00..m22 packed in s_axis_tdata, row major, m00 in the lowest bits.
// m_axis carries one quaternion per transaction: qw, qx, qy, qz packed from the
// lowest bit up in m_axis_tdata, with the degenerate flag on m_axis_tuser.
// Throughput is one matrix per cycle while the receiver does not stall. The path
// from input to output register is the decode register, RW = (DATA_WIDTH+FRAC_BITS+4)/2 square root cells,
// NW = DATA_WIDTH+FRAC_BITS+2 divider cells and the output register.
// The chain is one cell per root bit followed by one cell per quotient bit.
// When the receiver stalls, the whole chain holds and s_axis_tready drops
// together with it; the output register keeps its transaction until taken.
// Reset clears every valid bit in the chain and the output register.
// A non-positive radicand reports degenerate with all four parts zero, and
// every part saturates to the signed range of DATA_WIDTH.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // qw, qx, qy, qz, zero fill
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                      m_axis_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int TW    = DW + 3;
    localparam int DDW   = DW + 1;
    localparam int RW    = (DW + 3 + FRAC_BITS + 1) / 2;
    localparam int NW    = DW + 2 + FRAC_BITS;
    localparam int OUT_W = ((4*DATA_WIDTH+7)/8)*8;

    localparam logic [NW-1:0] POS_LIM = NW'((64'd1 << (DW-1)) - 64'd1);
    localparam logic [NW-1:0] NEG_LIM = NW'(64'd1 << (DW-1));
    localparam logic [DW-1:0] POS_MAX = DW'(POS_LIM);
    localparam logic [DW-1:0] NEG_MAX = DW'(NEG_LIM);
    localparam logic signed [TW-1:0] ONE = TW'(64'd1 << FRAC_BITS);

    logic en;
    logic m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic m_user_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ---- input decode ----
    logic signed [TW-1:0] m [9];
    logic signed [TW-1:0] trace;
    logic signed [TW-1:0] rad;
    logic signed [TW-1:0] dv [3];
    logic [1:0]           lead;
    logic                 deg;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            m[n] = TW'($signed(s_axis_tdata[n*DW +: DW]));
        end
        trace = m[0] + m[4] + m[8];
        deg   = 1'b0;
        if (trace > 0)
        begin
            lead  = rmq_pkg::LEAD_W;
            rad   = trace + ONE;
            dv[0] = m[7] - m[5];
            dv[1] = m[2] - m[6];
            dv[2] = m[3] - m[1];
        end
        else if (m[8] > m[0] && m[8] > m[4] || (m[8] > m[4] && !(m[4] > m[0])
                 && m[8] > m[0]))
        begin
            lead  = rmq_pkg::LEAD_Z;
            rad   = m[8] - m[0] - m[4] + ONE;
            dv[0] = m[2] + m[6];
            dv[1] = m[5] + m[7];
            dv[2] = m[3] - m[1];
        end
        else if (m[4] > m[0])
        begin
            lead  = rmq_pkg::LEAD_Y;
            rad   = m[4] - m[8] - m[0] + ONE;
            dv[0] = m[7] + m[5];
            dv[1] = m[1] + m[3];
            dv[2] = m[2] - m[6];
        end
        else
        begin
            lead  = rmq_pkg::LEAD_X;
            rad   = m[0] - m[4] - m[8] + ONE;
            dv[0] = m[3] + m[1];
            dv[1] = m[6] + m[2];
            dv[2] = m[7] - m[5];
        end
        if (rad <= 0)
        begin
            deg = 1'b1;
        end
    end

    // ---- square root chain, index 0 is the decode register ----
    rmq_pkg::rmq_ctrl_t sq_ctrl [RW+1];
    logic [2*RW-1:0]    sq_x    [RW+1];
    logic [RW-1:0]      sq_root [RW+1];
    logic [RW+1:0]      sq_rem  [RW+1];
    logic [DDW-1:0]     sq_d    [RW+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctrl[0] <= '0;
        end
        else if (en)
        begin
            sq_ctrl[0].valid      <= s_axis_tvalid;
            sq_ctrl[0].degenerate <= deg;
            sq_ctrl[0].lead       <= lead;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x[0]    <= (2*RW)'({rad[TW-2:0], {FRAC_BITS{1'b0}}});
            sq_root[0] <= '0;
            sq_rem[0]  <= '0;
            for (int n = 0; n < 3; n++)
            begin
                sq_d[0][n] <= dv[n][DDW-1:0];
            end
        end
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_sqrt
        rmq_sqrt_cell #(.RW(RW), .DDW(DDW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (sq_ctrl[s]),
            .x_in     (sq_x[s]),
            .root_in  (sq_root[s]),
            .rem_in   (sq_rem[s]),
            .d_in     (sq_d[s]),
            .ctrl_out (sq_ctrl[s+1]),
            .x_out    (sq_x[s+1]),
            .root_out (sq_root[s+1]),
            .rem_out  (sq_rem[s+1]),
            .d_out    (sq_d[s+1])
        );
    end

    // ---- divider chain ----
    rmq_pkg::rmq_ctrl_t dv_ctrl [NW+1];
    logic [RW-1:0]      dv_root [NW+1];
    logic               dv_neg  [NW+1][3];
    logic [NW-1:0]      dv_num  [NW+1][3];
    logic [RW+1:0]      dv_rem  [NW+1][3];
    logic [NW-1:0]      dv_quo  [NW+1][3];

    assign dv_ctrl[0] = sq_ctrl[RW];
    assign dv_root[0] = sq_root[RW];

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            logic [DDW-1:0] mag;
            dv_neg[0][n] = sq_d[RW][n][DDW-1];
            mag = dv_neg[0][n] ? (DDW'(0) - sq_d[RW][n]) : sq_d[RW][n];
            // magnitude * 2^FRAC_BITS plus root gives round half away from zero
            dv_num[0][n] = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(sq_root[RW]);
            dv_rem[0][n] = '0;
            dv_quo[0][n] = '0;
        end
    end

    for (genvar s = 0; s < NW; s++)
    begin : g_div
        rmq_div_cell #(.RW(RW), .NW(NW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_in  (dv_ctrl[s]),
            .root_in  (dv_root[s]),
            .neg_in   (dv_neg[s]),
            .num_in   (dv_num[s]),
            .rem_in   (dv_rem[s]),
            .quo_in   (dv_quo[s]),
            .ctrl_out (dv_ctrl[s+1]),
            .root_out (dv_root[s+1]),
            .neg_out  (dv_neg[s+1]),
            .num_out  (dv_num[s+1]),
            .rem_out  (dv_rem[s+1]),
            .quo_out  (dv_quo[s+1])
        );
    end

    // ---- saturate, route to components, output register ----
    rmq_pkg::rmq_ctrl_t fc;
    logic [NW-1:0]      lead_mag;
    logic [DW-1:0]      lead_val;
    logic [DW-1:0]      part [3];
    logic [DW-1:0]      qw, qx, qy, qz;
    logic [OUT_W-1:0]   m_data_next;

    assign fc       = dv_ctrl[NW];
    assign lead_mag = NW'(dv_root[NW] >> 1);
    assign lead_val = (lead_mag > POS_LIM) ? POS_MAX : lead_mag[DW-1:0];

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            if (dv_neg[NW][n])
            begin
                part[n] = (dv_quo[NW][n] > NEG_LIM) ? NEG_MAX
                                                    : DW'(NW'(0) - dv_quo[NW][n]);
            end
            else
            begin
                part[n] = (dv_quo[NW][n] > POS_LIM) ? POS_MAX : dv_quo[NW][n][DW-1:0];
            end
        end
        case (fc.lead)
            rmq_pkg::LEAD_W:
            begin
                qw = lead_val; qx = part[0]; qy = part[1]; qz = part[2];
            end
            rmq_pkg::LEAD_X:
            begin
                qx = lead_val; qy = part[0]; qz = part[1]; qw = part[2];
            end
            rmq_pkg::LEAD_Y:
            begin
                qy = lead_val; qz = part[0]; qx = part[1]; qw = part[2];
            end
            default:
            begin
                qz = lead_val; qx = part[0]; qy = part[1]; qw = part[2];
            end
        endcase
        if (fc.degenerate)
        begin
            m_data_next = '0;
        end
        else
        begin
            m_data_next = OUT_W'({qz, qy, qx, qw});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= fc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= fc.degenerate;
        end
    end

    // ---- checks ----
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_user_reg |-> m_data_reg == '0)
        else $error("degenerate result with nonzero parts");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_valid_reg || m_axis_tready))
        else $error("input ready out of step with output stall");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        sq_ctrl[RW].valid && !sq_ctrl[RW].degenerate |-> sq_root[RW] != '0)
        else $error("zero root on a non-degenerate item");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sq_ctrl[RW]) && $stable(dv_ctrl[NW]))
        else $error("chain advanced while stalled");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the rotation matrix to quaternion pipeline.
`timescale 1ns / 1ps

module testbench;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int IN_W = ((9*DW+7)/8)*8;
    localparam int OUT_W = ((4*DW+7)/8)*8;
    localparam int LATENCY = 51;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 500;
    localparam int ONE = 1 << FB;

    typedef struct packed {
        logic              degenerate;
        logic signed [DW-1:0] qz;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qw;
    } quat_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    quat_t expected_quats[$];
    int error_count = 0;
    int idle_cycles = 0;
    bit sender_idle_on;
    bit receiver_idle_on;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint scaled_part(longint d, longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((mag << FB) + root) / (root << 1);
        if (q > (64'd1 << 62))
            q = 64'd1 << 62;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [DW-1:0] saturate(longint v);
        longint hi;
        hi = (64'sd1 <<< (DW-1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v[DW-1:0];
    endfunction

    function automatic quat_t matrix_to_quat(logic [IN_W-1:0] data);
        longint m[3][3];
        longint q[4];
        longint trace;
        longint rad;
        longint unsigned root;
        int i, j, k;
        int nxt[3];
        quat_t res;
        nxt = '{1, 2, 0};
        for (int e = 0; e < 9; e++)
            m[e/3][e%3] = longint'($signed(data[e*DW +: DW]));
        q = '{0, 0, 0, 0};
        res = '0;
        trace = m[0][0] + m[1][1] + m[2][2];
        if (trace > 0)
        begin
            root = int_sqrt(longint'(trace + ONE) << FB);
            q[0] = root >> 1;
            q[1] = scaled_part(m[2][1] - m[1][2], root);
            q[2] = scaled_part(m[0][2] - m[2][0], root);
            q[3] = scaled_part(m[1][0] - m[0][1], root);
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = nxt[i];
            k = nxt[j];
            rad = m[i][i] - m[j][j] - m[k][k] + ONE;
            if (rad <= 0)
            begin
                res.degenerate = 1'b1;
                return res;
            end
            root = int_sqrt(rad << FB);
            q[1+i] = root >> 1;
            q[1+j] = scaled_part(m[j][i] + m[i][j], root);
            q[1+k] = scaled_part(m[k][i] + m[i][k], root);
            q[0] = scaled_part(m[k][j] - m[j][k], root);
        end
        res.qw = saturate(q[0]);
        res.qx = saturate(q[1]);
        res.qy = saturate(q[2]);
        res.qz = saturate(q[3]);
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_matrix(int e[9]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int n = 0; n < 9; n++)
            d[n*DW +: DW] = e[n][DW-1:0];
        return d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Directed rows: identity, 180 degree turns, a 90 degree turn, a zero matrix, extremes
    localparam int DIRECTED = 12;
    int directed_rows[DIRECTED][9] = '{
        '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE},
        '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE},
        '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE},
        '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE},
        '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768},
        '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
        '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
        '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0},
        '{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 32767},
        '{0, 0, 0, 0, 0, 0, 0, 0, 1}
    };
    // Typed-in results for the rows readable at a glance; others use the predictor
    bit directed_known[DIRECTED] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};
    quat_t directed_quats[DIRECTED] = '{
        '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384},
        '{1'b0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0},
        '{1'b0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0},
        '{1'b0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0},
        '0, '0, '0, '0, '0, '0, '0, '0
    };

    task automatic send_matrix(logic [IN_W-1:0] data, quat_t want);
        s_axis_tdata <= data;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_quats.push_back(want);
        // idle after the transaction, or keep valid high for the next one
        if (sender_idle_on && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    function automatic logic [IN_W-1:0] random_matrix();
        logic [IN_W-1:0] d;
        int e[9];
        int mode;
        mode = $urandom_range(9);
        for (int n = 0; n < 9; n++)
        begin
            if (mode < 4)
                e[n] = $signed(16'($urandom_range(0, 2*ONE))) - ONE;
            else if (mode < 6)
                e[n] = $urandom_range(0, 2*ONE) - ONE + ((n % 4 == 0) ? -ONE/2 : 0);
            else if (mode < 7)
                e[n] = ($urandom_range(1)) ? 32767 : -32768;
            else
                e[n] = $signed(16'($urandom));
        end
        // in the modes that lower the diagonal, raise one diagonal element to 0..ONE
        if (mode == 4 || mode == 5)
        begin
            e[$urandom_range(2) * 4] = $urandom_range(0, ONE);
        end
        d = pack_matrix(e);
        return d;
    endfunction

    initial
    begin
        logic [IN_W-1:0] d;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sender_idle_on = 1'b1;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < DIRECTED; r++)
        begin
            d = pack_matrix(directed_rows[r]);
            send_matrix(d, directed_known[r] ? directed_quats[r] : matrix_to_quat(d));
        end
        s_axis_tvalid <= 1'b0;
        // hold off until the pipeline drains
        while (expected_quats.size() != 0)
            @(posedge clk);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_idle_on = !(n >= 200 && n < 300);
            d = random_matrix();
            send_matrix(d, matrix_to_quat(d));
        end
        s_axis_tvalid <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls with a quiet stretch in the middle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !receiver_idle_on || ($urandom_range(99) >= 35);
    end

    initial
    begin
        receiver_idle_on = 1'b1;
        #20000;
        receiver_idle_on = 1'b0;
        #8000;
        receiver_idle_on = 1'b1;
    end

    always @(posedge clk)
    begin
        quat_t got;
        quat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[4*DW-1:0]};
            if (expected_quats.size() == 0)
            begin
                report_mismatch("unexpected transaction", 1, 0);
            end
            else
            begin
                want = expected_quats.pop_front();
                if (got.qw !== want.qw)
                    report_mismatch("qw", got.qw, want.qw);
                if (got.qx !== want.qx)
                    report_mismatch("qx", got.qx, want.qx);
                if (got.qy !== want.qy)
                    report_mismatch("qy", got.qy, want.qy);
                if (got.qz !== want.qz)
                    report_mismatch("qz", got.qz, want.qz);
                if (got.degenerate !== want.degenerate)
                    report_mismatch("degenerate", got.degenerate, want.degenerate);
            end
        end
    end

    // Watchdog: count cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
